// File: rtl/abpt_pkg.sv
// Shared types, constants and functions of the audio bucket peak tracker.
package abpt_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_SAMPLE_FORMAT = 2'd0;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT   = 2'd2;
    localparam logic [1:0] REG_BUCKET_COUNT  = 2'd3;

    localparam logic [31:0] ABS_MASK    = 32'h7FFF_FFFF;
    localparam logic [31:0] INF_BITS    = 32'h7F80_0000;
    localparam logic [16:0] MAX_BUCKETS = 17'd65536;
    localparam int          PROD_W      = 49;

    // Configuration as seen by the front and back parts.
    typedef struct packed {
        logic        sample_format;
        logic [15:0] channel_count;
        logic [31:0] frame_count;
        logic [16:0] bucket_count;
    } cfg_t;

    // One completed frame handed from the front to the back.
    typedef struct packed {
        logic [31:0] frame_number;
        logic [31:0] frame_peak;
        logic        last;
        logic        first;
    } frame_rec_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_DONE
    } back_state_t;

    // Bucket counts above the maximum act as the maximum.
    function automatic logic [16:0] eff_buckets(input logic [16:0] bc);
        return (bc > MAX_BUCKETS) ? MAX_BUCKETS : bc;
    endfunction

    // Exact float32 magnitude of an int16 sample divided by 32768.
    function automatic logic [31:0] pcm_magnitude(input logic [15:0] v);
        logic [15:0] a;
        logic [3:0]  p;
        logic [15:0] norm;
        logic [7:0]  expo;
        a = v[15] ? (16'd0 - v) : v;
        p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (a[i]) begin
                p = 4'(i);
            end
        end
        norm = a << (4'd15 - p);
        expo = 8'd112 + {4'd0, p};
        if (a == 16'd0) begin
            return 32'd0;
        end
        return {1'b0, expo, norm[14:0], 8'd0};
    endfunction

endpackage

// File: rtl/abpt_front.sv
// Front part: takes samples, tracks the frame peak and hands off completed frames.
module abpt_front import abpt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        fifo_full,
    output logic        push,
    output frame_rec_t  push_rec
);

    logic [15:0] pos_reg, pos_next;
    logic [31:0] fn_reg, fn_next;
    logic [31:0] peak_reg, peak_next;
    logic [31:0] mag, peak_upd;
    logic [15:0] pos_inc;
    logic        take;

    assign s_tready = !fifo_full;
    assign take     = s_tvalid && s_tready && (fn_reg < cfg.frame_count);

    // Sample magnitude; NaN never raises the peak.
    always_comb begin
        mag      = cfg.sample_format ? (s_tdata & ABS_MASK) : pcm_magnitude(s_tdata[15:0]);
        peak_upd = (mag <= INF_BITS && mag > peak_reg) ? mag : peak_reg;
        pos_inc  = pos_reg + 16'd1;
    end

    // Channel counting and frame completion.
    always_comb begin
        pos_next  = pos_reg;
        fn_next   = fn_reg;
        peak_next = peak_reg;
        push      = 1'b0;
        push_rec.frame_number = fn_reg;
        push_rec.frame_peak   = peak_upd;
        push_rec.last         = (fn_reg + 32'd1) == cfg.frame_count;
        push_rec.first        = fn_reg == 32'd0;
        if (take) begin
            if (pos_inc != cfg.channel_count) begin
                pos_next  = pos_inc;
                peak_next = peak_upd;
            end else begin
                push      = eff_buckets(cfg.bucket_count) != 17'd0;
                fn_next   = fn_reg + 32'd1;
                pos_next  = 16'd0;
                peak_next = 32'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= 16'd0;
            fn_reg   <= 32'd0;
            peak_reg <= 32'd0;
        end else begin
            pos_reg  <= pos_next;
            fn_reg   <= fn_next;
            peak_reg <= peak_next;
        end
    end

endmodule

// File: rtl/abpt_fifo.sv
// Two-entry queue of completed frames between the front and back parts.
module abpt_fifo import abpt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_rec_t push_rec,
    input  logic       pop,
    output logic       full,
    output logic       valid,
    output frame_rec_t head
);

    frame_rec_t  mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full  = count_reg == 2'd2;
    assign valid = count_reg != 2'd0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointer and fill count update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// File: rtl/abpt_back.sv
// Back part: places each frame in its bucket by a serial divide and keeps the bucket peak.
module abpt_back import abpt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        fifo_valid,
    input  frame_rec_t  head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    back_state_t        state_reg, state_next;
    frame_rec_t         rec_reg;
    logic [PROD_W-1:0]  quot_reg;
    logic [32:0]        rem_reg;
    logic [5:0]         cnt_reg;
    logic [16:0]        cur_bucket_reg;
    logic [31:0]        run_peak_reg;
    logic               out_valid_reg;
    logic [15:0]        out_index_reg;
    logic [31:0]        out_peak_reg;
    logic               out_last_reg;
    logic               load;
    logic [32:0]        rem_shift;
    logic               sub_ok;
    logic [16:0]        bucket;
    logic               new_bucket;
    logic [31:0]        run_new;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (fifo_valid) state_next = BK_MUL;
            BK_MUL:  state_next = BK_DIV;
            BK_DIV:  if (cnt_reg == 6'(PROD_W - 1)) state_next = BK_DONE;
            BK_DONE: if (!out_valid_reg || m_tready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Control outputs.
    always_comb begin
        pop  = (state_reg == BK_IDLE) && fifo_valid;
        load = (state_reg == BK_DONE) && (!out_valid_reg || m_tready);
    end

    // One restoring divide step and the bucket peak update.
    always_comb begin
        rem_shift  = {rem_reg[31:0], quot_reg[PROD_W-1]};
        sub_ok     = rem_shift >= {1'b0, cfg.frame_count};
        bucket     = quot_reg[16:0];
        new_bucket = rec_reg.first || (bucket != cur_bucket_reg);
        if (new_bucket || rec_reg.frame_peak > run_peak_reg) begin
            run_new = rec_reg.frame_peak;
        end else begin
            run_new = run_peak_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            cur_bucket_reg <= 17'd0;
            run_peak_reg   <= 32'd0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                cur_bucket_reg <= bucket;
                run_peak_reg   <= run_new;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (pop) begin
            rec_reg <= head;
        end
        case (state_reg)
            BK_MUL: begin
                quot_reg <= PROD_W'(rec_reg.frame_number)
                            * PROD_W'(eff_buckets(cfg.bucket_count));
                rem_reg  <= 33'd0;
                cnt_reg  <= 6'd0;
            end
            BK_DIV: begin
                rem_reg  <= sub_ok ? (rem_shift - {1'b0, cfg.frame_count}) : rem_shift;
                quot_reg <= {quot_reg[PROD_W-2:0], sub_ok};
                cnt_reg  <= cnt_reg + 6'd1;
            end
            default: ;
        endcase
        if (load) begin
            out_index_reg <= bucket[15:0];
            out_peak_reg  <= run_new;
            out_last_reg  <= rec_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_peak_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/audio_bucket_peak_tracker_top.sv
// Top level of the audio bucket peak tracker: registers, front, queue and back.
//
//   channel   dir   payload
//   s_        in    tdata[31:0] sample_bits
//   m_        out   tdata[15:0] bucket_index, [47:16] bucket_peak; tlast final_frame
//   cfg_      in    write only: cfg_index selects the register, cfg_wdata the value
//
// The back part loads each completed frame, multiplies its number 32x17 by the bucket
// count, divides the product by frame_count in a serial divide and hands off
// the result once the output is free. A two-word queue lets the front keep taking
// samples meanwhile; s_tready drops when it is full. Reset (aresetn low, synchronous)
// clears the state, counters and running peaks, but not the datapath registers.
module audio_bucket_peak_tracker_top import abpt_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // sample_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // bucket_index, bucket_peak
    output logic        m_tlast
);

    cfg_t       cfg_reg;
    logic       push, pop, fifo_full, fifo_valid;
    frame_rec_t push_rec, head;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sample_format <= 1'b0;
            cfg_reg.channel_count <= 16'd1;
            cfg_reg.frame_count   <= 32'd1;
            cfg_reg.bucket_count  <= 17'd1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAMPLE_FORMAT: cfg_reg.sample_format <= cfg_wdata[0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count <= cfg_wdata[15:0];
                REG_FRAME_COUNT:   cfg_reg.frame_count   <= cfg_wdata;
                REG_BUCKET_COUNT:  cfg_reg.bucket_count  <= cfg_wdata[16:0];
                default: ;
            endcase
        end
    end

    abpt_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .fifo_full(fifo_full), .push(push), .push_rec(push_rec)
    );

    abpt_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(push), .push_rec(push_rec),
        .pop(pop), .full(fifo_full), .valid(fifo_valid), .head(head)
    );

    abpt_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .fifo_valid(fifo_valid), .head(head), .pop(pop),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // The queue is never written while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && fifo_full))
        else $error("frame queue overflow");

    // The back part never pops an empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> fifo_valid)
        else $error("frame queue underflow");

    // A result is only reported below the bucket count.
    a_bucket_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[15:0]} < eff_buckets(cfg_reg.bucket_count)))
        else $error("bucket index out of range");

endmodule
